// ===== src/motion_segment_sequencer_core_assert.svh =====
// Assertion macros shared by the motion segment sequencer RTL.
`ifndef MOTION_SEGMENT_SEQUENCER_CORE_ASSERT_SVH
`define MOTION_SEGMENT_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset.
`define MSSC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent assertion on the block clock and reset.
`define MSSC_ASSERT(lbl, prop, msg) \
    `MSSC_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define MSSC_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define MSSC_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== src/mss_pkg.sv =====
// Constants, types and helper functions of the motion segment sequencer.
package mss_pkg;

    localparam int MAX_SEGMENTS_DEFAULT = 16;

    // Port widths.
    localparam int S_DATA_W = 104;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_GAIN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] START_DELAY_RST   = 16'd12000;
    localparam logic        LOOP_ENABLE_RST   = 1'b0;
    localparam logic [15:0] CMD_GAIN_RST      = 16'd4096;
    localparam logic [4:0]  SEGMENT_COUNT_RST = 5'd10;

    // Yaw wrap limits in Q3.12 radians.
    localparam logic signed [16:0] YAW_PI     = 17'sd12868;
    localparam logic signed [16:0] YAW_TWO_PI = 17'sd25736;

    // Pivot arithmetic: target = floor(ws * dur / (125 << 15)),
    // brake = floor(floor(ws * ws / 2^37) / 3), the last step by reciprocal.
    localparam int          TARGET_SHIFT = 15;
    localparam logic [6:0]  TARGET_MUL   = 7'd125;
    localparam int          BRAKE_SHIFT  = 37;
    localparam logic [24:0] DIV3_MUL     = 25'd22369622;
    localparam int          DIV3_SHIFT   = 26;
    localparam logic [3:0]  TIMEOUT_NUM  = 4'd9;
    localparam logic [3:0]  TIMEOUT_DEN  = 4'd5;

    typedef struct packed {
        logic signed [15:0] ang;
        logic signed [15:0] lin;
        logic [15:0]        dur;
    } seg_entry_t;

    // Magnitude of a signed 16-bit speed; the most negative value maps to 32768.
    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    // Truncates a magnitude product by 2^12 and saturates it to a signed 16-bit command.
    function automatic logic [15:0] sat_cmd(input logic [30:0] prod, input logic neg);
        logic [18:0] mag;
        mag = prod[30:12];
        if (!neg) begin
            return (mag > 19'd32767) ? 16'h7fff : mag[15:0];
        end
        return (mag > 19'd32768) ? 16'h8000 : (~mag[15:0] + 16'd1);
    endfunction

    // Absolute yaw change wrapped into (-pi, pi]; one correction step always suffices.
    function automatic logic [14:0] wrap_abs(input logic signed [14:0] a,
                                             input logic signed [14:0] b);
        logic signed [16:0] d;
        logic signed [16:0] w;
        d = {{2{a[14]}}, a} - {{2{b[14]}}, b};
        if (d > YAW_PI) begin
            w = d - YAW_TWO_PI;
        end else if (d <= -YAW_PI) begin
            w = d + YAW_TWO_PI;
        end else begin
            w = d;
        end
        return w[16] ? 15'(-w) : 15'(w);
    endfunction

endpackage

// ===== src/motion_segment_sequencer_core.sv =====
// Motion segment sequencer: plays a stored table of speed segments on tick requests.
// A tick that runs a segment goes through fetch, the multiply states and evaluation before
// its result; a tick that only waits or finishes goes from decode to output; a load gives none.
// Requests are taken only in idle, so a segment tick holds off the next while the shared
// multiplier forms five products in turn. Reset (aresetn, synchronous,
// active low) restores the registers and sequence state; the table keeps its contents.
`include "motion_segment_sequencer_core_assert.svh"

module motion_segment_sequencer_core #(
    parameter int MAX_SEGMENTS = mss_pkg::MAX_SEGMENTS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: clock_ms[31:0], yaw_sample[46:32], slot[50:47],
    // load_duration_ms[66:51], load_lin_speed[82:67], load_ang_speed[98:83], zero pad.
    input  logic [mss_pkg::S_DATA_W-1:0]   s_tdata,
    // Fields from bit 0: opcode[0], yaw_fresh[1].
    input  logic [mss_pkg::S_USER_W-1:0]   s_tuser,
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: lin_cmd[15:0], ang_cmd[31:16], segment_now[36:32], zero pad.
    output logic [mss_pkg::M_DATA_W-1:0]   m_tdata,
    // segment_ended.
    output logic                            m_tlast,
    // Field: sequence_done[0].
    output logic                            m_tuser,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Table address, segment index and count widths all follow from the table depth.
    localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int IDX_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int CNT_W  = (IDX_W > 5) ? IDX_W : 5;
    localparam int SLOT_W = (ADDR_W > 4) ? ADDR_W : 4;

    // Sequencer states. A request is taken in idle and decoded; a tick that plays a
    // segment then walks the shared multiplier through five products before it is
    // evaluated, and every result waits in the output state until the register frees.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_FETCH    = 4'd2;
    localparam logic [3:0] ST_MUL_LIN  = 4'd3;
    localparam logic [3:0] ST_MUL_SQ   = 4'd4;
    localparam logic [3:0] ST_MUL_TGT  = 4'd5;
    localparam logic [3:0] ST_MUL_DIV3 = 4'd6;
    localparam logic [3:0] ST_EVAL     = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic [15:0] start_delay_reg;
    logic        loop_enable_reg;
    logic [15:0] cmd_gain_reg;
    logic [4:0]  seg_count_reg;

    // Sequence state.
    logic                     clock_started_reg;
    logic                     finished_reg;
    logic                     entered_reg;
    logic                     yaw_seen_reg;
    logic [IDX_W-1:0]         seg_idx_reg;
    logic [31:0]              run_start_reg;
    logic [31:0]              seg_start_reg;
    logic [23:0]              turned_sum_reg;
    logic signed [14:0]       prev_yaw_reg;
    logic signed [14:0]       held_yaw_reg;

    // Captured request.
    logic                     in_op_reg;
    logic                     in_fresh_reg;
    logic [31:0]              in_clk_reg;
    logic signed [14:0]       in_yaw_reg;
    logic [3:0]               in_slot_reg;
    logic [15:0]              in_dur_reg;
    logic signed [15:0]       in_lin_reg;
    logic signed [15:0]       in_ang_reg;

    // Segment table. It is a single-port synchronous memory: a load writes it in the
    // decode cycle and a tick reads it there, so the two never overlap and the read
    // data register stays put for the rest of the tick.
    mss_pkg::seg_entry_t      seg_mem [MAX_SEGMENTS];
    mss_pkg::seg_entry_t      mem_rd_reg;

    // Working registers of the segment evaluation.
    logic [31:0]              now_reg;
    logic [31:0]              seg_t_reg;
    logic [63:0]              mul_p_reg;
    logic [30:0]              ws_reg;
    logic [30:0]              lin_prod_reg;
    logic [24:0]              y_reg;
    logic [31:0]              tgt_hi_reg;
    logic [23:0]              sum_reg;

    // Pending result and output register.
    logic [15:0]              res_lin_reg;
    logic [15:0]              res_ang_reg;
    logic                     res_end_reg;
    logic                     res_done_reg;
    logic [4:0]               res_idx_reg;
    logic                     out_valid_reg;
    logic [15:0]              out_lin_reg;
    logic [15:0]              out_ang_reg;
    logic                     out_end_reg;
    logic                     out_done_reg;
    logic [4:0]               out_idx_reg;

    logic                     in_accept;
    logic                     out_load;

    // Decode of a tick.
    logic signed [14:0]       held_eff;
    logic [31:0]              run_start_eff;
    logic [31:0]              now_val;
    logic [CNT_W-1:0]         count_w;
    logic [CNT_W-1:0]         idx_w;
    logic [SLOT_W-1:0]        slot_w;
    logic                     slot_ok;
    logic                     dec_early;
    logic                     dec_end;
    logic                     dec_loop;
    logic                     dec_done;
    logic                     dec_run;

    // Evaluation of a segment.
    logic [15:0]              ang_mag;
    logic [15:0]              lin_mag;
    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic [63:0]              mul_prod;
    logic [24:0]              sum_full;
    logic [23:0]              sum_sat;
    logic [23:0]              brake;
    logic [25:0]              lhs_base;
    logic [32:0]              lhs;
    logic                     pivot;
    logic                     tgt_hit;
    logic                     timeout;
    logic                     timed_done;
    logic                     ev_done;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    // The output register takes the pending result once it is empty or being emptied.
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_idx_reg, out_ang_reg, out_lin_reg};
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_done_reg;

    // Tick decode. A yaw sample that comes with the tick is already in force, and the
    // first nonzero clock becomes the run start within the same tick.
    always_comb begin
        held_eff      = in_fresh_reg ? in_yaw_reg : held_yaw_reg;
        run_start_eff = clock_started_reg ? run_start_reg : in_clk_reg;
        now_val       = in_clk_reg - run_start_eff;
        count_w       = (32'(seg_count_reg) > 32'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                                 : CNT_W'(seg_count_reg);
        idx_w         = CNT_W'(seg_idx_reg);
        slot_w        = SLOT_W'(in_slot_reg);
        slot_ok       = 32'(in_slot_reg) < 32'(MAX_SEGMENTS);
        // Waiting for the clock, inside the start delay, or already done: a plain stop.
        dec_early     = (!clock_started_reg && (in_clk_reg == 32'd0))
                        || (now_val < 32'(start_delay_reg)) || finished_reg;
        dec_end       = !dec_early && (idx_w >= count_w);
        dec_loop      = dec_end && loop_enable_reg;
        dec_done      = dec_end && !loop_enable_reg;
        dec_run       = !dec_early && !dec_end;
    end

    // Shared multiplier operands, one product per state.
    always_comb begin
        ang_mag = mss_pkg::abs16(mem_rd_reg.ang);
        lin_mag = mss_pkg::abs16(mem_rd_reg.lin);
        unique case (state_reg)
            ST_FETCH: begin
                mul_a = 32'(ang_mag);
                mul_b = 32'(cmd_gain_reg);
            end
            ST_MUL_LIN: begin
                mul_a = 32'(lin_mag);
                mul_b = 32'(cmd_gain_reg);
            end
            ST_MUL_SQ: begin
                mul_a = 32'(ws_reg);
                mul_b = 32'(ws_reg);
            end
            ST_MUL_TGT: begin
                mul_a = 32'(ws_reg);
                mul_b = 32'(mem_rd_reg.dur);
            end
            ST_MUL_DIV3: begin
                mul_a = 32'(y_reg);
                mul_b = 32'(mss_pkg::DIV3_MUL);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // Segment end test. For a pivot the target angle is compared without a divide:
    // sum + brake >= floor(P / (125 * 2^15)) holds exactly when
    // (sum + brake + 1) * 125 exceeds floor(P / 2^15).
    always_comb begin
        sum_full   = 25'(turned_sum_reg)
                     + 25'(mss_pkg::wrap_abs(held_yaw_reg, prev_yaw_reg));
        sum_sat    = sum_full[24] ? 24'hff_ffff : sum_full[23:0];
        brake      = mul_p_reg[mss_pkg::DIV3_SHIFT+23:mss_pkg::DIV3_SHIFT];
        lhs_base   = 26'(sum_reg) + 26'(brake) + 26'd1;
        lhs        = 33'(lhs_base) * 33'(mss_pkg::TARGET_MUL);
        tgt_hit    = lhs > 33'(tgt_hi_reg);
        timeout    = (35'(seg_t_reg) * 35'(mss_pkg::TIMEOUT_DEN))
                     > (35'(mem_rd_reg.dur) * 35'(mss_pkg::TIMEOUT_NUM));
        timed_done = seg_t_reg >= 32'(mem_rd_reg.dur);
        pivot      = (mem_rd_reg.lin == 16'sd0) && (mem_rd_reg.ang != 16'sd0)
                     && yaw_seen_reg;
        ev_done    = pivot ? (tgt_hit || timeout) : timed_done;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (in_op_reg || dec_loop) begin
                    state_next = ST_IDLE;
                end else if (dec_run) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_FETCH:    state_next = ST_MUL_LIN;
            ST_MUL_LIN:  state_next = ST_MUL_SQ;
            ST_MUL_SQ:   state_next = ST_MUL_TGT;
            ST_MUL_TGT:  state_next = ST_MUL_DIV3;
            ST_MUL_DIV3: state_next = ST_EVAL;
            ST_EVAL:     state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control and sequence state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            start_delay_reg   <= mss_pkg::START_DELAY_RST;
            loop_enable_reg   <= mss_pkg::LOOP_ENABLE_RST;
            cmd_gain_reg      <= mss_pkg::CMD_GAIN_RST;
            seg_count_reg     <= mss_pkg::SEGMENT_COUNT_RST;
            clock_started_reg <= 1'b0;
            finished_reg      <= 1'b0;
            entered_reg       <= 1'b0;
            yaw_seen_reg      <= 1'b0;
            seg_idx_reg       <= '0;
            run_start_reg     <= 32'd0;
            seg_start_reg     <= 32'd0;
            turned_sum_reg    <= 24'd0;
            prev_yaw_reg      <= 15'sd0;
            held_yaw_reg      <= 15'sd0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    mss_pkg::CFG_START_DELAY:   start_delay_reg <= cfg_wdata;
                    mss_pkg::CFG_LOOP_ENABLE:   loop_enable_reg <= cfg_wdata[0];
                    mss_pkg::CFG_CMD_GAIN:      cmd_gain_reg    <= cfg_wdata;
                    mss_pkg::CFG_SEGMENT_COUNT: seg_count_reg   <= cfg_wdata[4:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if ((state_reg == ST_DECODE) && !in_op_reg) begin
                if (in_fresh_reg) begin
                    held_yaw_reg <= in_yaw_reg;
                    yaw_seen_reg <= 1'b1;
                end
                if (!clock_started_reg && (in_clk_reg != 32'd0)) begin
                    clock_started_reg <= 1'b1;
                end
                // A loop restarts the table without a fresh start delay.
                if (dec_loop) begin
                    run_start_reg <= in_clk_reg - 32'(start_delay_reg);
                    seg_idx_reg   <= '0;
                    entered_reg   <= 1'b0;
                end else if (!clock_started_reg && (in_clk_reg != 32'd0)) begin
                    run_start_reg <= in_clk_reg;
                end
                if (dec_done) begin
                    finished_reg <= 1'b1;
                end
                if (dec_run && !entered_reg) begin
                    entered_reg    <= 1'b1;
                    seg_start_reg  <= now_val;
                    turned_sum_reg <= 24'd0;
                    prev_yaw_reg   <= held_eff;
                end
            end

            if (state_reg == ST_EVAL) begin
                if (pivot) begin
                    turned_sum_reg <= sum_reg;
                    prev_yaw_reg   <= held_yaw_reg;
                end
                if (ev_done) begin
                    seg_idx_reg <= seg_idx_reg + IDX_W'(1);
                    entered_reg <= 1'b0;
                end
            end
        end
    end

    // Request capture, multiplier pipeline and result data.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_op_reg    <= s_tuser[0];
            in_fresh_reg <= s_tuser[1];
            in_clk_reg   <= s_tdata[31:0];
            in_yaw_reg   <= s_tdata[46:32];
            in_slot_reg  <= s_tdata[50:47];
            in_dur_reg   <= s_tdata[66:51];
            in_lin_reg   <= s_tdata[82:67];
            in_ang_reg   <= s_tdata[98:83];
        end

        mul_p_reg <= mul_prod;

        unique case (state_reg)
            ST_DECODE: begin
                now_reg      <= now_val;
                res_lin_reg  <= 16'd0;
                res_ang_reg  <= 16'd0;
                res_end_reg  <= 1'b0;
                res_done_reg <= dec_done;
                res_idx_reg  <= idx_w[4:0];
            end
            ST_FETCH: begin
                seg_t_reg <= now_reg - seg_start_reg;
            end
            ST_MUL_LIN: begin
                ws_reg <= mul_p_reg[30:0];
            end
            ST_MUL_SQ: begin
                lin_prod_reg <= mul_p_reg[30:0];
            end
            ST_MUL_TGT: begin
                y_reg <= mul_p_reg[mss_pkg::BRAKE_SHIFT+24:mss_pkg::BRAKE_SHIFT];
            end
            ST_MUL_DIV3: begin
                tgt_hi_reg <= mul_p_reg[mss_pkg::TARGET_SHIFT+31:mss_pkg::TARGET_SHIFT];
                sum_reg    <= sum_sat;
            end
            ST_EVAL: begin
                // A closing tick reports the index of the segment it closes, which is
                // still the register value here.
                res_lin_reg  <= ev_done ? 16'd0
                                        : mss_pkg::sat_cmd(lin_prod_reg, mem_rd_reg.lin[15]);
                res_ang_reg  <= ev_done ? 16'd0
                                        : mss_pkg::sat_cmd(ws_reg, mem_rd_reg.ang[15]);
                res_end_reg  <= ev_done;
                res_done_reg <= 1'b0;
                res_idx_reg  <= idx_w[4:0];
            end
            default: ;
        endcase

        if (out_load) begin
            out_lin_reg  <= res_lin_reg;
            out_ang_reg  <= res_ang_reg;
            out_end_reg  <= res_end_reg;
            out_done_reg <= res_done_reg;
            out_idx_reg  <= res_idx_reg;
        end
    end

    // Segment table memory. Slots beyond the table depth are ignored.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DECODE) && in_op_reg && slot_ok) begin
            seg_mem[slot_w[ADDR_W-1:0]] <= '{ang: in_ang_reg, lin: in_lin_reg,
                                              dur: in_dur_reg};
        end
        if ((state_reg == ST_DECODE) && !in_op_reg && dec_run) begin
            mem_rd_reg <= seg_mem[idx_w[ADDR_W-1:0]];
        end
    end

    `MSSC_ASSERT(a_load_no_result, (state_reg == ST_DECODE && in_op_reg) |=> (state_reg == ST_IDLE), "a load request must not produce a result")
    `MSSC_ASSERT(a_result_from_out, $rose(out_valid_reg) |-> $past(state_reg == ST_OUT), "a result appeared outside the output state")
    `MSSC_ASSERT(a_finish_after_clock, finished_reg |-> clock_started_reg, "sequence finished before the clock started")
    `MSSC_ASSERT(a_index_range, 32'(seg_idx_reg) <= 32'(MAX_SEGMENTS), "segment index beyond the table")
    `MSSC_ASSERT(a_end_flags, out_valid_reg |-> !(out_end_reg && out_done_reg), "segment end and sequence done on one result")

endmodule

// ===== dv/motion_segment_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the motion segment sequencer core.
module motion_segment_sequencer_core_tb;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;
    localparam int SEGMENT_SLOTS = 16;
    localparam int IN_DATA_W = mss_pkg::S_DATA_W;
    localparam int CFG_W = mss_pkg::CFG_DATA_W;
    // Idle wait after the last queued command, long enough for any load or silent tick
    // still inside the pipeline to leave it.
    localparam int SETTLE_CYCLES = 16;
    localparam logic [31:0] TURN_SUM_MAX = 32'd16777215;

    // One request as the testbench sees it, before packing onto the stream.
    typedef struct {
        logic               op;
        logic [31:0]        clock_ms;
        logic signed [14:0] yaw;
        logic               fresh;
        logic [3:0]         slot;
        logic [15:0]        dur;
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } request_t;

    // One speed command, unpacked from the result stream.
    typedef struct {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        logic               ended;
        logic               done;
        logic [4:0]         seg_now;
    } command_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mss_pkg::S_DATA_W-1:0]   s_tdata;
    logic [mss_pkg::S_USER_W-1:0]   s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mss_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;
    logic                           cfg_wr_en;
    logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mss_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // The scoreboard keeps its own copy of the segment table, the registers and the
    // sequencing state, plays every accepted request through it and queues the command
    // that the block ought to produce. Results are checked in order against that queue.
    class command_scoreboard;
        mss_pkg::seg_entry_t seg_table [SEGMENT_SLOTS];
        logic [15:0]        start_delay;
        logic               loop_on;
        logic [15:0]        cmd_gain;
        logic [4:0]         seg_count;
        logic               clock_started;
        logic               seq_finished;
        logic               seg_entered;
        logic               yaw_seen;
        logic [31:0]        run_start;
        logic [31:0]        seg_start;
        logic [4:0]         seg_index;
        logic [23:0]        turned_sum;
        logic signed [14:0] prev_yaw;
        logic signed [14:0] held_yaw;
        command_t           pending_cmds [$];
        int unsigned        fail_count;

        function new();
            start_delay   = mss_pkg::START_DELAY_RST;
            loop_on       = mss_pkg::LOOP_ENABLE_RST;
            cmd_gain      = mss_pkg::CMD_GAIN_RST;
            seg_count     = mss_pkg::SEGMENT_COUNT_RST;
            clock_started = 1'b0;
            seq_finished  = 1'b0;
            seg_entered   = 1'b0;
            yaw_seen      = 1'b0;
            run_start     = '0;
            seg_start     = '0;
            seg_index     = '0;
            turned_sum    = '0;
            prev_yaw      = '0;
            held_yaw      = '0;
            fail_count    = 0;
        endfunction

        function void write_register(input logic [mss_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [mss_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                mss_pkg::CFG_START_DELAY:   start_delay = value;
                mss_pkg::CFG_LOOP_ENABLE:   loop_on = value[0];
                mss_pkg::CFG_CMD_GAIN:      cmd_gain = value;
                mss_pkg::CFG_SEGMENT_COUNT: seg_count = value[4:0];
            endcase
        endfunction

        function int unsigned outstanding();
            return pending_cmds.size();
        endfunction

        function void queue_cmd(input logic signed [15:0] lin, input logic signed [15:0] ang,
                                input logic ended, input logic done, input logic [4:0] idx);
            command_t c;
            c.lin = lin;
            c.ang = ang;
            c.ended = ended;
            c.done = done;
            c.seg_now = idx;
            pending_cmds.insert(pending_cmds.size(), c);
        endfunction

        // Speed times the Q4.12 scale, truncated toward zero and clipped to 16 bits.
        function logic signed [15:0] scaled_speed(input logic signed [15:0] speed);
            longint sp;
            longint sc;
            longint prod;
            sp = speed;
            sc = cmd_gain;
            prod = (sp * sc) / 4096;
            if (prod > 32767) begin
                prod = 32767;
            end else if (prod < -32768) begin
                prod = -32768;
            end
            return prod[15:0];
        endfunction

        // Magnitude of the heading change, wrapped into (-pi, pi].
        function logic [31:0] yaw_step(input logic signed [14:0] a, input logic signed [14:0] b);
            int d;
            d = int'(a) - int'(b);
            while (d > int'(mss_pkg::YAW_PI)) d -= int'(mss_pkg::YAW_TWO_PI);
            while (d <= -int'(mss_pkg::YAW_PI)) d += int'(mss_pkg::YAW_TWO_PI);
            return (d < 0) ? -d : d;
        endfunction

        function void play_tick(input request_t r);
            mss_pkg::seg_entry_t seg;
            logic [31:0]     now;
            logic [31:0]     seg_time;
            logic [4:0]      limit;
            logic            ends;
            longint          w;
            longint unsigned mag;
            longint unsigned target;
            longint unsigned ws;
            longint unsigned brake;
            longint unsigned sum;
            if (r.fresh) begin
                held_yaw = r.yaw;
                yaw_seen = 1'b1;
            end
            if (!clock_started) begin
                if (r.clock_ms == 0) begin
                    queue_cmd(16'sd0, 16'sd0, 1'b0, 1'b0, seg_index);
                    return;
                end
                run_start = r.clock_ms;
                clock_started = 1'b1;
            end
            now = r.clock_ms - run_start;
            if (now < start_delay || seq_finished) begin
                queue_cmd(16'sd0, 16'sd0, 1'b0, 1'b0, seg_index);
                return;
            end
            limit = (seg_count > SEGMENT_SLOTS) ? 5'(SEGMENT_SLOTS) : seg_count;
            if (seg_index >= limit) begin
                // End of the table: either rewind silently or report completion once.
                if (loop_on) begin
                    run_start = r.clock_ms - start_delay;
                    seg_index = '0;
                    seg_entered = 1'b0;
                end else begin
                    seq_finished = 1'b1;
                    queue_cmd(16'sd0, 16'sd0, 1'b0, 1'b1, seg_index);
                end
                return;
            end
            seg = seg_table[seg_index];
            if (!seg_entered) begin
                seg_entered = 1'b1;
                seg_start = now;
                turned_sum = '0;
                prev_yaw = held_yaw;
            end
            seg_time = now - seg_start;
            if (seg.lin == 0 && seg.ang != 0 && yaw_seen) begin
                // Pivot: integrate the turned angle and stop early by the braking angle.
                w = seg.ang;
                mag = (w < 0) ? -w : w;
                target = mag * seg.dur * cmd_gain / 64'd4096000;
                ws = mag * cmd_gain;
                brake = ws * ws / (64'd6 << 36);
                sum = turned_sum + yaw_step(held_yaw, prev_yaw);
                turned_sum = (sum > TURN_SUM_MAX) ? TURN_SUM_MAX[23:0] : sum[23:0];
                prev_yaw = held_yaw;
                ends = (turned_sum + brake >= target) || (seg_time * 64'd5 > seg.dur * 64'd9);
            end else begin
                ends = (seg_time >= seg.dur);
            end
            if (ends) begin
                queue_cmd(16'sd0, 16'sd0, 1'b1, 1'b0, seg_index);
                seg_index++;
                seg_entered = 1'b0;
            end else begin
                queue_cmd(scaled_speed(seg.lin), scaled_speed(seg.ang), 1'b0, 1'b0, seg_index);
            end
        endfunction

        function void note_request(input request_t r);
            if (r.op == OP_LOAD) begin
                seg_table[r.slot] = '{ang: r.ang, lin: r.lin, dur: r.dur};
            end else begin
                play_tick(r);
            end
        endfunction

        function void flag(input string field, input logic signed [31:0] want,
                           input logic signed [31:0] seen);
            $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
            fail_count++;
        endfunction

        function void check_command(input logic [mss_pkg::M_DATA_W-1:0] data,
                                    input logic ended, input logic done);
            command_t got;
            command_t want;
            got.lin = data[15:0];
            got.ang = data[31:16];
            got.seg_now = data[36:32];
            got.ended = ended;
            got.done = done;
            if (pending_cmds.size() == 0) begin
                $display("%0t: no command expected, got tdata %h tlast %b tuser %b",
                         $time, data, ended, done);
                fail_count++;
                return;
            end
            want = pending_cmds.pop_front();
            if (got.lin !== want.lin) flag("lin_cmd", want.lin, got.lin);
            if (got.ang !== want.ang) flag("ang_cmd", want.ang, got.ang);
            if (got.seg_now !== want.seg_now) flag("segment_now", want.seg_now, got.seg_now);
            if (got.ended !== want.ended) flag("segment_ended", want.ended, got.ended);
            if (got.done !== want.done) flag("sequence_done", want.done, got.done);
        endfunction
    endclass

    command_scoreboard sb;
    logic [31:0]       clock_now;
    int                yaw_now;
    logic              steady_phase;

    motion_segment_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle lengths: mostly none or a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic request_t make_load(input logic [3:0] slot, input logic [15:0] dur,
                                           input logic signed [15:0] lin,
                                           input logic signed [15:0] ang);
        request_t r;
        r.op = OP_LOAD;
        r.clock_ms = $urandom;
        r.yaw = 15'($urandom);
        r.fresh = 1'($urandom);
        r.slot = slot;
        r.dur = dur;
        r.lin = lin;
        r.ang = ang;
        return r;
    endfunction

    // Table entries: a good share of pivots, mostly short durations so that segments
    // turn over often, with the odd very long one.
    function automatic request_t random_load(input logic [3:0] slot);
        request_t r;
        int roll;
        r = make_load(slot, 16'd0, 16'sd0, 16'sd0);
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            r.dur = 16'($urandom_range(0, 400));
        end else if (roll < 95) begin
            r.dur = 16'($urandom_range(401, 5000));
        end else begin
            r.dur = 16'($urandom);
        end
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            r.ang = (roll < 5) ? 16'($urandom) : 16'($urandom_range(1, 12000));
            if ($urandom_range(0, 1) == 1) r.ang = -r.ang;
        end else if (roll < 90) begin
            r.lin = 16'($urandom);
            r.ang = 16'($urandom);
        end else if (roll >= 95) begin
            r.lin = 16'($urandom);
        end
        return r;
    endfunction

    function automatic request_t tick_at(input logic [31:0] clk_ms, input int yaw,
                                         input logic fresh);
        request_t r;
        clock_now = clk_ms;
        yaw_now = yaw;
        r.op = OP_TICK;
        r.clock_ms = clk_ms;
        r.fresh = fresh;
        // A stale sample is ignored, so its field carries noise.
        r.yaw = fresh ? 15'(yaw) : 15'($urandom);
        r.slot = 4'($urandom);
        r.dur = 16'($urandom);
        r.lin = 16'($urandom);
        r.ang = 16'($urandom);
        return r;
    endfunction

    // The clock mostly creeps forward; sometimes it leaps, jumps anywhere (often
    // backwards) or drops to zero. The heading drifts, with rare out-of-range samples.
    function automatic request_t random_tick();
        int roll;
        logic [31:0] clk_ms;
        roll = $urandom_range(0, 99);
        clk_ms = clock_now;
        if (roll < 70) begin
            clk_ms += $urandom_range(0, 40);
        end else if (roll < 88) begin
            clk_ms += $urandom_range(41, 600);
        end else if (roll < 96) begin
            clk_ms += $urandom_range(601, 70000);
        end else if (roll < 99) begin
            clk_ms = $urandom;
        end else begin
            clk_ms = '0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            yaw_now += int'($urandom_range(0, 1200)) - 600;
            if (yaw_now > int'(mss_pkg::YAW_PI)) begin
                yaw_now -= int'(mss_pkg::YAW_TWO_PI);
            end else if (yaw_now <= -int'(mss_pkg::YAW_PI)) begin
                yaw_now += int'(mss_pkg::YAW_TWO_PI);
            end
        end else if (roll >= 95) begin
            yaw_now = int'($urandom_range(0, 32767)) - 16384;
        end
        return tick_at(clk_ms, yaw_now, $urandom_range(0, 99) < 85);
    endfunction

    // Presents one request at the falling edge and holds it until the block takes it.
    task automatic send_request(input request_t r);
        int gap;
        gap = steady_phase ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'({r.ang, r.lin, r.dur, r.slot, r.yaw, r.clock_ms});
        s_tuser <= {r.fresh, r.op};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        sb.note_request(r);
    endtask

    // Waits for every queued command, then lets loads and silent ticks run out.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mss_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_register(idx, value);
    endtask

    task automatic write_settings(input logic [15:0] delay_ms, input logic loop_flag,
                                  input logic [15:0] scale, input logic [4:0] count);
        write_reg(mss_pkg::CFG_START_DELAY, delay_ms);
        write_reg(mss_pkg::CFG_LOOP_ENABLE, CFG_W'(loop_flag));
        write_reg(mss_pkg::CFG_CMD_GAIN, scale);
        write_reg(mss_pkg::CFG_SEGMENT_COUNT, CFG_W'(count));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One phase: drain, reprogramme, then a burst of ticks with loads sprinkled in.
    // Some phases send back to back so that the block sees no idle cycles at all.
    task automatic run_phase(input logic [15:0] delay_ms, input logic loop_flag,
                             input logic [15:0] scale, input logic [4:0] count,
                             input int n_items);
        settle();
        write_settings(delay_ms, loop_flag, scale, count);
        steady_phase = ($urandom_range(0, 3) == 0);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                send_request(random_load(4'($urandom)));
            end else begin
                send_request(random_tick());
            end
        end
    endtask

    // Result side: ready in bursts of varying length, separated by stalls.
    initial begin
        int burst;
        int stall;
        m_tready = 1'b0;
        forever begin
            burst = $urandom_range(1, 40);
            @(negedge aclk);
            m_tready <= 1'b1;
            repeat (burst - 1) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            sb.check_command(m_tdata, m_tlast, m_tuser);
        end
    end

    initial begin
        int i;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_index = mss_pkg::CFG_START_DELAY;
        cfg_wdata = '0;
        sb = new();
        clock_now = '0;
        yaw_now = 0;
        steady_phase = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        write_settings(16'd100, 1'b1, 16'd4096, 5'd6);

        // Fill the whole table first so that no unwritten entry is ever played.
        // The first entries hold the field extremes: full-scale timed speeds, a zero
        // duration, a gentle pivot, a pivot whose braking angle exceeds its target, a
        // maximum duration with the smallest speeds, and a standstill.
        send_request(make_load(4'd0, 16'd50, 16'sh7fff, 16'sh8000));
        send_request(make_load(4'd1, 16'd0, 16'sh8000, 16'sh7fff));
        send_request(make_load(4'd2, 16'd300, 16'sd0, 16'sd4096));
        send_request(make_load(4'd3, 16'd100, 16'sd0, 16'sh8000));
        send_request(make_load(4'd4, 16'hffff, 16'sd1, -16'sd1));
        send_request(make_load(4'd5, 16'd20, 16'sd0, 16'sd0));
        for (i = 6; i < SEGMENT_SLOTS; i++) send_request(random_load(4'(i)));

        // Clock not yet valid, with heading samples at both ends of the field.
        send_request(tick_at(32'd0, 16383, 1'b1));
        send_request(tick_at(32'd0, -16384, 1'b1));
        // The run starts here, then waits out the start delay to the millisecond.
        send_request(tick_at(32'd1000, 12868, 1'b1));
        send_request(tick_at(32'd1099, 12868, 1'b0));
        send_request(tick_at(32'd1100, -12867, 1'b1));
        // First segment times out, the zero-length one closes at once, then the pivot.
        send_request(tick_at(32'd1150, -12867, 1'b1));
        send_request(tick_at(32'd1150, 0, 1'b1));
        send_request(tick_at(32'd1160, 0, 1'b1));

        // Looping phases cover the register extremes, including an empty table
        // and a segment count beyond the table size.
        run_phase(16'd0, 1'b1, 16'd4096, 5'd6, 160);
        run_phase(16'd65535, 1'b1, 16'd65535, 5'd16, 160);
        run_phase(16'd250, 1'b1, 16'd0, 5'd3, 160);
        run_phase(16'd40, 1'b1, 16'd2048, 5'd31, 160);
        run_phase(16'd0, 1'b1, 16'd4096, 5'd0, 30);
        run_phase(16'd1000, 1'b1, 16'd12000, 5'd1, 160);
        repeat (5) begin
            run_phase(16'($urandom_range(0, 600)), 1'b1, 16'($urandom),
                      5'($urandom_range(1, 16)), 160);
        end
        // Looping off last: the sequence completes once and then only stops follow.
        run_phase(16'd300, 1'b0, 16'd4096, 5'd4, 160);
        settle();

        if (sb.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Guard against a hang: 20 ms is many times the slowest legitimate run.
    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
